@@ hdl/lspf_pkg.sv @@
// Shared widths and the snapshot type of the least-squares plane fit.
package lspf_pkg;

   localparam int COORD_W     = 24;
   localparam int MAX_POINTS  = 1024;
   localparam int COUNT_W     = $clog2(MAX_POINTS + 1);
   localparam int PROD_W      = 2 * COORD_W;
   // Sums of products and plain sums, wide enough for a full set of points.
   localparam int SQ_W        = PROD_W + COUNT_W - 1;
   localparam int LIN_W       = COORD_W + COUNT_W - 1;
   // Cofactors are products of two sums, determinants products of three.
   localparam int CF_W        = 2 * SQ_W + 2;
   localparam int ACC_W       = 3 * SQ_W + 4;
   localparam int SLOPE_W     = 32;
   localparam int OFFSET_W    = 24;
   localparam int FRAC_SHIFT  = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam int REQ_DATA_W  = ((3 * COORD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = 2 * SLOPE_W + OFFSET_W + COUNT_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_USER_W  = 2;

   typedef struct packed {
      logic [SQ_W-1:0]    sxx;
      logic [SQ_W-1:0]    sxy;
      logic [SQ_W-1:0]    syy;
      logic [SQ_W-1:0]    sxz;
      logic [SQ_W-1:0]    syz;
      logic [LIN_W-1:0]   sx;
      logic [LIN_W-1:0]   sy;
      logic [LIN_W-1:0]   sz;
      logic [COUNT_W-1:0] n;
   } snap_type;

endpackage

@@ hdl/lspf_accum.sv @@
// Front end: registers the point products and accumulates the running sums.
module lspf_accum import lspf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [COORD_W-1:0] x_coord,
   input  logic signed [COORD_W-1:0] y_coord,
   input  logic signed [COORD_W-1:0] z_coord,
   input  logic                      last_point,
   input  logic                      q_full,
   output logic                      push,
   output snap_type                  push_data
);

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_last_ff;
   logic signed [PROD_W-1:0] pxx_ff, pxy_ff, pyy_ff, pxz_ff, pyz_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   snap_type                 sums_ff, sums_in, sums_nxt;
   logic                     advance;
   logic                     under;

   // The only stall is a finished set that cannot yet enter the queue.
   assign advance     = !(s1_valid_ff && s1_last_ff && q_full);
   assign in_ready    = advance;
   assign s1_valid_in = advance ? in_valid : s1_valid_ff;
   assign push        = s1_valid_ff && s1_last_ff && !q_full;
   assign under       = sums_ff.n < COUNT_W'(MAX_POINTS);

   always_comb begin
      sums_nxt = sums_ff;
      if (under) begin
         sums_nxt.sxx = sums_ff.sxx + {{(SQ_W-PROD_W){pxx_ff[PROD_W-1]}}, pxx_ff};
         sums_nxt.sxy = sums_ff.sxy + {{(SQ_W-PROD_W){pxy_ff[PROD_W-1]}}, pxy_ff};
         sums_nxt.syy = sums_ff.syy + {{(SQ_W-PROD_W){pyy_ff[PROD_W-1]}}, pyy_ff};
         sums_nxt.sxz = sums_ff.sxz + {{(SQ_W-PROD_W){pxz_ff[PROD_W-1]}}, pxz_ff};
         sums_nxt.syz = sums_ff.syz + {{(SQ_W-PROD_W){pyz_ff[PROD_W-1]}}, pyz_ff};
         sums_nxt.sx  = sums_ff.sx + {{(LIN_W-COORD_W){x_ff[COORD_W-1]}}, x_ff};
         sums_nxt.sy  = sums_ff.sy + {{(LIN_W-COORD_W){y_ff[COORD_W-1]}}, y_ff};
         sums_nxt.sz  = sums_ff.sz + {{(LIN_W-COORD_W){z_ff[COORD_W-1]}}, z_ff};
         sums_nxt.n   = sums_ff.n + 1'b1;
      end
   end

   assign push_data = sums_nxt;

   always_comb begin
      sums_in = sums_ff;
      if (s1_valid_ff && advance) begin
         if (s1_last_ff) begin
            sums_in = '0;
         end else begin
            sums_in = sums_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sums_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         sums_ff     <= sums_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_last_ff <= last_point;
         pxx_ff     <= x_coord * x_coord;
         pxy_ff     <= x_coord * y_coord;
         pyy_ff     <= y_coord * y_coord;
         pxz_ff     <= x_coord * z_coord;
         pyz_ff     <= y_coord * z_coord;
         x_ff       <= x_coord;
         y_ff       <= y_coord;
         z_ff       <= z_coord;
      end
   end

endmodule

@@ hdl/lspf_queue.sv @@
// Short queue of finished sum snapshots between the accumulator and the solver.
module lspf_queue import lspf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  snap_type push_data,
   input  logic     pop,
   output snap_type head,
   output logic     full,
   output logic     empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   snap_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/lspf_solve.sv @@
// Back end: solves the normal equations by cofactors and serial division.
module lspf_solve import lspf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  snap_type              head,
   input  logic                  empty,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int A_W       = SQ_W;
   localparam int BIT_W     = $clog2(A_W);
   localparam int NUM_W     = ACC_W + FRAC_SHIFT;
   localparam int DCNT_W    = $clog2(NUM_W);
   localparam int Q_W       = SLOPE_W + 1;
   localparam int N_STEPS   = 24;
   localparam int STEP_W    = $clog2(N_STEPS);
   localparam int USER_SING = 0;
   localparam int USER_SAT  = 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_DIVSET = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_ROUND  = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   localparam logic [3:0] OP_M00 = 4'd0;
   localparam logic [3:0] OP_M01 = 4'd1;
   localparam logic [3:0] OP_M02 = 4'd2;
   localparam logic [3:0] OP_M11 = 4'd3;
   localparam logic [3:0] OP_M12 = 4'd4;
   localparam logic [3:0] OP_M22 = 4'd5;
   localparam logic [3:0] OP_B0  = 4'd6;
   localparam logic [3:0] OP_B1  = 4'd7;
   localparam logic [3:0] OP_B2  = 4'd8;
   localparam logic [3:0] OP_C00 = 4'd9;
   localparam logic [3:0] OP_C01 = 4'd10;
   localparam logic [3:0] OP_C02 = 4'd11;
   localparam logic [3:0] OP_C11 = 4'd12;
   localparam logic [3:0] OP_C12 = 4'd13;
   localparam logic [3:0] OP_C22 = 4'd14;

   localparam logic [3:0] DST_NONE = 4'd0;
   localparam logic [3:0] DST_C00  = 4'd1;
   localparam logic [3:0] DST_C01  = 4'd2;
   localparam logic [3:0] DST_C02  = 4'd3;
   localparam logic [3:0] DST_C11  = 4'd4;
   localparam logic [3:0] DST_C12  = 4'd5;
   localparam logic [3:0] DST_C22  = 4'd6;
   localparam logic [3:0] DST_DET  = 4'd7;
   localparam logic [3:0] DST_DN0  = 4'd8;
   localparam logic [3:0] DST_DN1  = 4'd9;
   localparam logic [3:0] DST_DN2  = 4'd10;

   typedef struct packed {
      logic [3:0] opa;
      logic [3:0] opb;
      logic       sub;
      logic [3:0] dest;
   } uop_type;

   // Cofactors of the symmetric matrix, then the determinant and the three
   // Cramer numerators expanded along the replaced column.
   function automatic uop_type ucode(input logic [STEP_W-1:0] step);
      uop_type u;
      unique case (step)
         5'd0:    u = '{OP_M11, OP_M22, 1'b0, DST_NONE};
         5'd1:    u = '{OP_M12, OP_M12, 1'b1, DST_C00};
         5'd2:    u = '{OP_M12, OP_M02, 1'b0, DST_NONE};
         5'd3:    u = '{OP_M01, OP_M22, 1'b1, DST_C01};
         5'd4:    u = '{OP_M01, OP_M12, 1'b0, DST_NONE};
         5'd5:    u = '{OP_M11, OP_M02, 1'b1, DST_C02};
         5'd6:    u = '{OP_M00, OP_M22, 1'b0, DST_NONE};
         5'd7:    u = '{OP_M02, OP_M02, 1'b1, DST_C11};
         5'd8:    u = '{OP_M01, OP_M02, 1'b0, DST_NONE};
         5'd9:    u = '{OP_M00, OP_M12, 1'b1, DST_C12};
         5'd10:   u = '{OP_M00, OP_M11, 1'b0, DST_NONE};
         5'd11:   u = '{OP_M01, OP_M01, 1'b1, DST_C22};
         5'd12:   u = '{OP_M00, OP_C00, 1'b0, DST_NONE};
         5'd13:   u = '{OP_M01, OP_C01, 1'b0, DST_NONE};
         5'd14:   u = '{OP_M02, OP_C02, 1'b0, DST_DET};
         5'd15:   u = '{OP_B0,  OP_C00, 1'b0, DST_NONE};
         5'd16:   u = '{OP_B1,  OP_C01, 1'b0, DST_NONE};
         5'd17:   u = '{OP_B2,  OP_C02, 1'b0, DST_DN0};
         5'd18:   u = '{OP_B0,  OP_C01, 1'b0, DST_NONE};
         5'd19:   u = '{OP_B1,  OP_C11, 1'b0, DST_NONE};
         5'd20:   u = '{OP_B2,  OP_C12, 1'b0, DST_DN1};
         5'd21:   u = '{OP_B0,  OP_C02, 1'b0, DST_NONE};
         5'd22:   u = '{OP_B1,  OP_C12, 1'b0, DST_NONE};
         5'd23:   u = '{OP_B2,  OP_C22, 1'b0, DST_DN2};
         default: u = '{OP_M00, OP_M00, 1'b0, DST_NONE};
      endcase
      return u;
   endfunction

   logic [2:0]           state_ff, state_in;
   snap_type             snap_ff, snap_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [A_W-1:0]       ash_ff, ash_in;
   logic [ACC_W-1:0]     bsh_ff, bsh_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [CF_W-1:0]      c00_ff, c01_ff, c02_ff, c11_ff, c12_ff, c22_ff;
   logic [CF_W-1:0]      c00_in, c01_in, c02_in, c11_in, c12_in, c22_in;
   logic [ACC_W-1:0]     det_ff, det_in, dn0_ff, dn0_in, dn1_ff, dn1_in, dn2_ff, dn2_in;
   logic [1:0]           k_ff, k_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [ACC_W-1:0]     den_ff, den_in;
   logic [ACC_W-1:0]     rem_ff, rem_in;
   logic [Q_W-1:0]       q_ff, q_in;
   logic                 ovf_ff, ovf_in;
   logic                 neg_ff, neg_in;
   logic [DCNT_W-1:0]    dcnt_ff, dcnt_in;
   logic [SLOPE_W-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic [OFFSET_W-1:0]  cz_ff, cz_in;
   logic                 sat_ff, sat_in;
   logic                 sing_ff, sing_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   uop_type              uop;
   logic [A_W-1:0]       a_val;
   logic [ACC_W-1:0]     b_val;
   logic                 term_sub;
   logic [ACC_W-1:0]     acc_sum, acc_fin;
   logic                 bit_last;
   logic [ACC_W-1:0]     dn_sel, dn_mag;
   logic [ACC_W:0]       rem_sh;
   logic                 rem_ge;
   logic                 twice_ge;
   logic [Q_W:0]         q_rnd, lim, mag;
   logic                 over;
   logic [SLOPE_W-1:0]   coef;

   assign uop = ucode(step_ff);

   always_comb begin
      unique case (uop.opa)
         OP_M00:  a_val = snap_ff.sxx;
         OP_M01:  a_val = snap_ff.sxy;
         OP_M02:  a_val = {{(A_W-LIN_W){snap_ff.sx[LIN_W-1]}}, snap_ff.sx};
         OP_M11:  a_val = snap_ff.syy;
         OP_M12:  a_val = {{(A_W-LIN_W){snap_ff.sy[LIN_W-1]}}, snap_ff.sy};
         OP_M22:  a_val = {{(A_W-COUNT_W){1'b0}}, snap_ff.n};
         OP_B0:   a_val = snap_ff.sxz;
         OP_B1:   a_val = snap_ff.syz;
         OP_B2:   a_val = {{(A_W-LIN_W){snap_ff.sz[LIN_W-1]}}, snap_ff.sz};
         default: a_val = '0;
      endcase
   end

   always_comb begin
      unique case (uop.opb)
         OP_M02:  b_val = {{(ACC_W-LIN_W){snap_ff.sx[LIN_W-1]}}, snap_ff.sx};
         OP_M12:  b_val = {{(ACC_W-LIN_W){snap_ff.sy[LIN_W-1]}}, snap_ff.sy};
         OP_M22:  b_val = {{(ACC_W-COUNT_W){1'b0}}, snap_ff.n};
         OP_M00:  b_val = {{(ACC_W-SQ_W){snap_ff.sxx[SQ_W-1]}}, snap_ff.sxx};
         OP_M01:  b_val = {{(ACC_W-SQ_W){snap_ff.sxy[SQ_W-1]}}, snap_ff.sxy};
         OP_M11:  b_val = {{(ACC_W-SQ_W){snap_ff.syy[SQ_W-1]}}, snap_ff.syy};
         OP_C00:  b_val = {{(ACC_W-CF_W){c00_ff[CF_W-1]}}, c00_ff};
         OP_C01:  b_val = {{(ACC_W-CF_W){c01_ff[CF_W-1]}}, c01_ff};
         OP_C02:  b_val = {{(ACC_W-CF_W){c02_ff[CF_W-1]}}, c02_ff};
         OP_C11:  b_val = {{(ACC_W-CF_W){c11_ff[CF_W-1]}}, c11_ff};
         OP_C12:  b_val = {{(ACC_W-CF_W){c12_ff[CF_W-1]}}, c12_ff};
         OP_C22:  b_val = {{(ACC_W-CF_W){c22_ff[CF_W-1]}}, c22_ff};
         default: b_val = '0;
      endcase
   end

   // Shift-and-add multiply: the top multiplier bit carries negative weight.
   assign bit_last = bit_ff == BIT_W'(A_W - 1);
   assign term_sub = uop.sub ^ bit_last;
   assign acc_sum  = term_sub ? acc_ff - bsh_ff : acc_ff + bsh_ff;
   assign acc_fin  = ash_ff[0] ? acc_sum : acc_ff;

   always_comb begin
      unique case (k_ff)
         2'd0:    dn_sel = dn0_ff;
         2'd1:    dn_sel = dn1_ff;
         default: dn_sel = dn2_ff;
      endcase
   end
   assign dn_mag = dn_sel[ACC_W-1] ? -dn_sel : dn_sel;

   // Restoring division, one quotient bit per cycle.
   assign rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign rem_ge = rem_sh >= {1'b0, den_ff};

   // Round half away from zero on the magnitude, then clip.
   assign twice_ge = {rem_ff, 1'b0} >= {1'b0, den_ff};
   assign q_rnd    = {1'b0, q_ff} + {{Q_W{1'b0}}, twice_ge};
   always_comb begin
      if (k_ff == 2'd2) begin
         lim = neg_ff ? (Q_W+1)'(1) << (OFFSET_W - 1) : ((Q_W+1)'(1) << (OFFSET_W - 1)) - 1'b1;
      end else begin
         lim = neg_ff ? (Q_W+1)'(1) << (SLOPE_W - 1) : ((Q_W+1)'(1) << (SLOPE_W - 1)) - 1'b1;
      end
   end
   assign over = ovf_ff || (q_rnd > lim);
   assign mag  = over ? lim : q_rnd;
   assign coef = neg_ff ? SLOPE_W'(-mag) : mag[SLOPE_W-1:0];

   always_comb begin
      state_in     = state_ff;
      snap_in      = snap_ff;
      step_in      = step_ff;
      bit_in       = bit_ff;
      ash_in       = ash_ff;
      bsh_in       = bsh_ff;
      acc_in       = acc_ff;
      c00_in       = c00_ff;
      c01_in       = c01_ff;
      c02_in       = c02_ff;
      c11_in       = c11_ff;
      c12_in       = c12_ff;
      c22_in       = c22_ff;
      det_in       = det_ff;
      dn0_in       = dn0_ff;
      dn1_in       = dn1_ff;
      dn2_in       = dn2_ff;
      k_in         = k_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      ovf_in       = ovf_ff;
      neg_in       = neg_ff;
      dcnt_in      = dcnt_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      sat_in       = sat_ff;
      sing_in      = sing_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      pop          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               snap_in  = head;
               step_in  = '0;
               acc_in   = '0;
               sat_in   = 1'b0;
               sing_in  = 1'b0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            ash_in   = a_val;
            bsh_in   = b_val;
            bit_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            ash_in = ash_ff >> 1;
            bsh_in = bsh_ff << 1;
            bit_in = bit_ff + 1'b1;
            acc_in = acc_fin;
            if (bit_last) begin
               if (uop.dest != DST_NONE) begin
                  acc_in = '0;
               end
               unique case (uop.dest)
                  DST_C00: c00_in = acc_fin[CF_W-1:0];
                  DST_C01: c01_in = acc_fin[CF_W-1:0];
                  DST_C02: c02_in = acc_fin[CF_W-1:0];
                  DST_C11: c11_in = acc_fin[CF_W-1:0];
                  DST_C12: c12_in = acc_fin[CF_W-1:0];
                  DST_C22: c22_in = acc_fin[CF_W-1:0];
                  DST_DET: det_in = acc_fin;
                  DST_DN0: dn0_in = acc_fin;
                  DST_DN1: dn1_in = acc_fin;
                  DST_DN2: dn2_in = acc_fin;
                  default: ;
               endcase
               if (step_ff == STEP_W'(N_STEPS - 1)) begin
                  k_in = '0;
                  if (det_ff == '0) begin
                     sing_in  = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_DIVSET;
                  end
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_DIVSET: begin
            if (k_ff == 2'd2) begin
               num_in = {{FRAC_SHIFT{1'b0}}, dn_mag};
            end else begin
               num_in = {dn_mag, {FRAC_SHIFT{1'b0}}};
            end
            neg_in   = dn_sel[ACC_W-1] ^ det_ff[ACC_W-1];
            den_in   = det_ff[ACC_W-1] ? -det_ff : det_ff;
            rem_in   = '0;
            q_in     = '0;
            ovf_in   = 1'b0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = rem_ge ? ACC_W'(rem_sh - {1'b0, den_ff}) : rem_sh[ACC_W-1:0];
            num_in  = num_ff << 1;
            q_in    = {q_ff[Q_W-2:0], rem_ge};
            ovf_in  = ovf_ff | q_ff[Q_W-1];
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(NUM_W - 1)) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            sat_in = sat_ff | over;
            unique case (k_ff)
               2'd0:    cx_in = coef;
               2'd1:    cy_in = coef;
               default: cz_in = coef[OFFSET_W-1:0];
            endcase
            if (k_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_DIVSET;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (sing_ff) begin
                  rsp_data_in = {{(RSP_DATA_W-RSP_FIELD_W){1'b0}}, snap_ff.n,
                                 {(OFFSET_W + 2 * SLOPE_W){1'b0}}};
                  rsp_user_in = '0;
                  rsp_user_in[USER_SING] = 1'b1;
               end else begin
                  rsp_data_in = {{(RSP_DATA_W-RSP_FIELD_W){1'b0}}, snap_ff.n,
                                 cz_ff, cy_ff, cx_ff};
                  rsp_user_in = '0;
                  rsp_user_in[USER_SAT] = sat_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff     <= snap_in;
      step_ff     <= step_in;
      bit_ff      <= bit_in;
      ash_ff      <= ash_in;
      bsh_ff      <= bsh_in;
      acc_ff      <= acc_in;
      c00_ff      <= c00_in;
      c01_ff      <= c01_in;
      c02_ff      <= c02_in;
      c11_ff      <= c11_in;
      c12_ff      <= c12_in;
      c22_ff      <= c22_in;
      det_ff      <= det_in;
      dn0_ff      <= dn0_in;
      dn1_ff      <= dn1_in;
      dn2_ff      <= dn2_in;
      k_ff        <= k_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      ovf_ff      <= ovf_in;
      neg_ff      <= neg_in;
      dcnt_ff     <= dcnt_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      sat_ff      <= sat_in;
      sing_ff     <= sing_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A singular result carries zero coefficients and no clipping mark.
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[USER_SING]) |->
         (rsp_data_ff[OFFSET_W + 2 * SLOPE_W - 1:0] == '0) && !rsp_user_ff[USER_SAT])
      else $error("singular result with non-zero coefficients");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (step_ff < STEP_W'(N_STEPS)))
      else $error("microcode step out of range");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the completion state");

endmodule

@@ hdl/least_squares_plane_fit.sv @@
// Top level of the least-squares plane fit Z = A*X + B*Y + C.
//
// Points arrive on the req_ channel, one per transaction, at up to one per
// cycle. Each point's products are registered and added to running sums in
// the next cycle. A point with req_tlast high closes the set: its sums, with
// the point count, move into a two-entry queue and the sums clear for the
// next set, which may begin in the very next cycle.
// The solver takes one set at a time from the queue. It forms the six
// cofactors, the determinant and three numerators as 24 products on a
// shift-and-add multiplier that takes the multiplier bits in turn, then
// divides serially, one quotient bit per cycle, for each of the three
// coefficients; a singular set skips the divisions.
// The result sits in an output register until rsp_tready takes it, and the
// solver waits with its next result meanwhile; points keep streaming in
// until the queue is full, and then a closing point waits in the product
// register and holds req_tready low. Synchronous reset clears the sums, the
// queue and any result.
module least_squares_plane_fit import lspf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // x_coord [23:0], y_coord [47:24], z_coord [71:48]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // slope_x [31:0], slope_y [63:32], offset_z [87:64], point_count [98:88]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // singular [0], saturated [1]
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   logic     q_full, q_empty, q_push, q_pop;
   snap_type q_push_data, q_head;

   lspf_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .x_coord    (req_tdata[COORD_W-1:0]),
      .y_coord    (req_tdata[2*COORD_W-1:COORD_W]),
      .z_coord    (req_tdata[3*COORD_W-1:2*COORD_W]),
      .last_point (req_tlast),
      .q_full     (q_full),
      .push       (q_push),
      .push_data  (q_push_data)
   );

   lspf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   lspf_solve u_solve (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .empty      (q_empty),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ sim/tb_least_squares_plane_fit.sv @@
// Self-checking testbench for the least-squares plane fit block.
module tb_least_squares_plane_fit import lspf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // A generous cycle limit: every set costs a full solve, and each point and
   // each result may see a gap or a stall.
   localparam int CYCLE_LIMIT = 10_000_000;
   // Cycles let pass after the last result, one solve and a little more.
   localparam int DRAIN_CYCLES = 2200;

   typedef logic signed [255:0] wide_type;
   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct {
      logic signed [SLOPE_W-1:0]  slope_x;
      logic signed [SLOPE_W-1:0]  slope_y;
      logic signed [OFFSET_W-1:0] offset_z;
      bit                         singular;
      bit                         saturated;
      logic [COUNT_W-1:0]         point_count;
   } fit_type;

   typedef struct {
      coord_type x, y, z;
      bit        last;
      bit        typed;   // expected fit read off by hand rather than predicted
      fit_type   fit;
   } row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   least_squares_plane_fit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Running sums of the set being collected, as the block keeps them.
   longint      sum_xx, sum_xy, sum_yy, sum_xz, sum_yz, sum_x, sum_y, sum_z;
   int unsigned set_points;

   fit_type     pending_fits[$];
   int          error_count = 0;
   int          fits_checked = 0;
   int          singular_fits = 0;
   int          saturated_fits = 0;
   int          points_sent = 0;
   int          cycle_count = 0;
   bit          calm = 1'b0;   // no idling on either side when set
   row_type     table_rows[$];

   function automatic wide_type det3(wide_type a, wide_type b, wide_type c,
                                     wide_type d, wide_type e, wide_type f,
                                     wide_type g, wide_type h, wide_type i);
      return a * (e * i - f * h) - b * (d * i - f * g) + c * (d * h - e * g);
   endfunction

   // Rounds num * 2^shift / den to nearest, ties away from zero, and clips
   // the magnitude to a signed field of the given width.
   function automatic logic [63:0] round_quotient(wide_type num, wide_type den,
                                                  int shift, int width,
                                                  inout bit clipped);
      logic [255:0] n, d, q, r, lim;
      bit           neg;
      if (num == 0) return '0;
      neg = (num < 0) ^ (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      n = n << shift;
      q = n / d;
      r = n % d;
      if (r >= d - r) q = q + 1;
      lim = neg ? (256'd1 << (width - 1)) : ((256'd1 << (width - 1)) - 1);
      if (q > lim) begin
         q = lim;
         clipped = 1'b1;
      end
      return neg ? -q[63:0] : q[63:0];
   endfunction

   // Adds one accepted point to the sums; a closing point yields the fit.
   function automatic bit take_point(coord_type x, coord_type y, coord_type z, bit last,
                                     output fit_type fit);
      longint   lx, ly, lz;
      wide_type mxx, mxy, myy, mx, my, mn, bxz, byz, bz, det;
      bit       clipped;
      lx = x; ly = y; lz = z;
      fit = '{default: 0};
      if (set_points < MAX_POINTS) begin
         sum_xx += lx * lx; sum_xy += lx * ly; sum_yy += ly * ly;
         sum_xz += lx * lz; sum_yz += ly * lz;
         sum_x += lx; sum_y += ly; sum_z += lz;
         set_points++;
      end
      if (!last) return 1'b0;
      mxx = sum_xx; mxy = sum_xy; myy = sum_yy; mx = sum_x; my = sum_y;
      mn = set_points; bxz = sum_xz; byz = sum_yz; bz = sum_z;
      det = det3(mxx, mxy, mx, mxy, myy, my, mx, my, mn);
      fit.point_count = set_points[COUNT_W-1:0];
      if (det == 0) begin
         fit.singular = 1'b1;
      end else begin
         clipped = 1'b0;
         fit.slope_x = SLOPE_W'(round_quotient(
            det3(bxz, mxy, mx, byz, myy, my, bz, my, mn),
            det, FRAC_SHIFT, SLOPE_W, clipped));
         fit.slope_y = SLOPE_W'(round_quotient(
            det3(mxx, bxz, mx, mxy, byz, my, mx, bz, mn),
            det, FRAC_SHIFT, SLOPE_W, clipped));
         fit.offset_z = OFFSET_W'(round_quotient(
            det3(mxx, mxy, bxz, mxy, myy, byz, mx, my, bz),
            det, 0, OFFSET_W, clipped));
         fit.saturated = clipped;
      end
      sum_xx = 0; sum_xy = 0; sum_yy = 0; sum_xz = 0; sum_yz = 0;
      sum_x = 0; sum_y = 0; sum_z = 0; set_points = 0;
      return 1'b1;
   endfunction

   // Offers one point and waits for its transaction. Where a hand-read fit
   // is given, it stands in the queue in place of the predicted one.
   task automatic send_point(coord_type x, coord_type y, coord_type z, bit last,
                             bit typed = 1'b0, fit_type typed_fit = '{default: 0});
      fit_type fit;
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      points_sent++;
      if (take_point(x, y, z, last, fit))
         pending_fits.insert(pending_fits.size(), typed ? typed_fit : fit);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic add_row(int x, int y, int z, bit last, bit typed = 1'b0,
                          fit_type fit = '{default: 0});
      row_type row;
      row.x = coord_type'(x); row.y = coord_type'(y); row.z = coord_type'(z);
      row.last = last;
      row.typed = typed; row.fit = fit;
      table_rows.insert(table_rows.size(), row);
   endtask

   // Random coordinate, in one of several spreads.
   function automatic coord_type pick_coord(int spread);
      unique case (spread)
         0:       return coord_type'($urandom);
         1:       return coord_type'($signed($urandom_range(0, 8191)) - 4096);
         default: return coord_type'($signed($urandom_range(0, 511)) - 256);
      endcase
   endfunction

   // Sends one set of points. Most sets are small and of general position;
   // some lie on one line, so the normal matrix is singular.
   task automatic send_set(int size, int shape);
      coord_type x, y, z, step;
      int        spread;
      spread = $urandom_range(0, 2);
      step = pick_coord(2);
      for (int k = 0; k < size; k++) begin
         if (shape == 1) begin
            x = coord_type'(k * step);
            y = coord_type'(3 * k * step);
         end else begin
            x = pick_coord(spread);
            y = pick_coord(spread);
         end
         z = pick_coord(spread);
         send_point(x, y, z, k == size - 1);
      end
   endtask

   // Result side: stalls in random bursts.
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Checks each result transaction against the oldest expected fit.
   always @(posedge clock) begin
      fit_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.slope_x     = rsp_tdata[31:0];
         got.slope_y     = rsp_tdata[63:32];
         got.offset_z    = rsp_tdata[87:64];
         got.point_count = rsp_tdata[98:88];
         got.singular    = rsp_tuser[0];
         got.saturated   = rsp_tuser[1];
         if (pending_fits.size() == 0) begin
            $display("%0t: result with no fit expected, got %p", $time, got);
            error_count++;
         end else begin
            want = pending_fits.pop_front();
            fits_checked++;
            if (want.singular) singular_fits++;
            if (want.saturated) saturated_fits++;
            if (got.slope_x !== want.slope_x) begin
               $display("%0t: slope_x expected %0d actual %0d", $time, want.slope_x,
                        got.slope_x);
               error_count++;
            end
            if (got.slope_y !== want.slope_y) begin
               $display("%0t: slope_y expected %0d actual %0d", $time, want.slope_y,
                        got.slope_y);
               error_count++;
            end
            if (got.offset_z !== want.offset_z) begin
               $display("%0t: offset_z expected %0d actual %0d", $time, want.offset_z,
                        got.offset_z);
               error_count++;
            end
            if (got.singular !== want.singular) begin
               $display("%0t: singular expected %0b actual %0b", $time, want.singular,
                        got.singular);
               error_count++;
            end
            if (got.saturated !== want.saturated) begin
               $display("%0t: saturated expected %0b actual %0b", $time, want.saturated,
                        got.saturated);
               error_count++;
            end
            if (got.point_count !== want.point_count) begin
               $display("%0t: point_count expected %0d actual %0d", $time,
                        want.point_count, got.point_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d fits outstanding", $time, pending_fits.size());
         $display("least_squares_plane_fit regression: fail");
         $finish;
      end
   end

   initial begin
      fit_type fit;
      int      shape, size;
      sum_xx = 0; sum_xy = 0; sum_yy = 0; sum_xz = 0; sum_yz = 0;
      sum_x = 0; sum_y = 0; sum_z = 0; set_points = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // A lone point: the matrix is singular, coefficients are zero.
      fit = '{default: 0}; fit.singular = 1'b1; fit.point_count = COUNT_W'(1);
      add_row(0, 0, 0, 1'b1, 1'b1, fit);
      // Two points at the coordinate extremes: still singular.
      fit.point_count = COUNT_W'(2);
      add_row(8388607, 8388607, 8388607, 1'b0);
      add_row(-8388608, -8388608, -8388608, 1'b1, 1'b1, fit);
      // Three collinear points.
      fit.point_count = COUNT_W'(3);
      add_row(1, 1, 1, 1'b0);
      add_row(2, 2, 2, 1'b0);
      add_row(3, 3, 3, 1'b1, 1'b1, fit);
      // The plane z = x: slope one in Q15.16, the rest zero.
      fit = '{default: 0}; fit.slope_x = 65536; fit.point_count = COUNT_W'(3);
      add_row(0, 0, 0, 1'b0);
      add_row(256, 0, 256, 1'b0);
      add_row(0, 256, 0, 1'b1, 1'b1, fit);
      // A steep plane, so that the slopes clip.
      add_row(0, 0, 0, 1'b0);
      add_row(1, 0, 8388607, 1'b0);
      add_row(0, 1, -8388608, 1'b1);
      // An offset far beyond its range, by extrapolation.
      add_row(8388607, 0, 8388607, 1'b0);
      add_row(8388606, 1, -8388608, 1'b0);
      add_row(8388607, 1, 0, 1'b1);
      // Mixed extremes over four points.
      add_row(-8388608, 8388607, 0, 1'b0);
      add_row(8388607, -8388608, -1, 1'b0);
      add_row(-1, 0, 8388607, 1'b0);
      add_row(0, -1, -8388608, 1'b1);

      foreach (table_rows[i])
         send_point(table_rows[i].x, table_rows[i].y, table_rows[i].z,
                    table_rows[i].last, table_rows[i].typed, table_rows[i].fit);
      req_tvalid <= 1'b0;

      // Hold points back until every fit so far has come out.
      while (pending_fits.size() != 0) @(posedge clock);

      while (points_sent < table_rows.size() + 830) begin
         if (points_sent > table_rows.size() + 730) calm = 1'b1;
         shape = $urandom_range(0, 19);
         if (shape < 2) size = $urandom_range(1, 2);
         else if (shape < 3) size = $urandom_range(9, 40);
         else size = $urandom_range(3, 8);
         send_set(size, shape == 19 ? 1 : 0);
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      while (pending_fits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d points; checked %0d fits, %0d singular and %0d clipped.",
               points_sent, fits_checked, singular_fits, saturated_fits);
      $display("Sets ranged from a lone point to forty points, with gaps and stalls.");
      if (error_count == 0 && pending_fits.size() == 0) begin
         $display("least_squares_plane_fit regression: pass");
      end else begin
         $display("least_squares_plane_fit regression: fail");
      end
      $finish;
   end

endmodule

@@ least_squares_plane_fit.f @@
hdl/lspf_pkg.sv
hdl/lspf_accum.sv
hdl/lspf_queue.sv
hdl/lspf_solve.sv
hdl/least_squares_plane_fit.sv
sim/tb_least_squares_plane_fit.sv
